/* sv/imufd_pkg.sv */
`default_nettype none

package imufd_pkg;

    // frame layout
    localparam int FRAME_BYTES = 12;
    localparam int FRAME_WORDS = FRAME_BYTES / 2;
    localparam int AXES        = 3;
    localparam int COUNT_W     = 4;
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(15);

    // field widths
    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 16;
    localparam int SCALE_W = 24;
    localparam int RES_W   = 40;
    localparam int STAMP_W = 64;
    localparam int PROD_W  = (WORD_W + 1) + (SCALE_W + 1);

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 304;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_ACCEL_SCALE = 3'd0,
        CFG_GYRO_SCALE  = 3'd1,
        CFG_SRC_X       = 3'd2,
        CFG_SRC_Y       = 3'd3,
        CFG_SRC_Z       = 3'd4,
        CFG_SIGN_X      = 3'd5,
        CFG_SIGN_Y      = 3'd6,
        CFG_SIGN_Z      = 3'd7
    } cfg_idx_t;

    // source component codes
    localparam logic [1:0] SRC_COMP_X = 2'd0;
    localparam logic [1:0] SRC_COMP_Y = 2'd1;
    localparam logic [1:0] SRC_COMP_Z = 2'd2;
    localparam logic [1:0] SRC_NONE   = 2'd3;

    // sign codes
    localparam logic [1:0] SIGN_POS = 2'b01;
    localparam logic [1:0] SIGN_NEG = 2'b11;

    // reset values
    localparam logic [SCALE_W-1:0] ACCEL_SCALE_RST = SCALE_W'(16);
    localparam logic [SCALE_W-1:0] GYRO_SCALE_RST  = SCALE_W'(1024);

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [WORD_W:0]   sel_word_t;
    typedef logic [RES_W-1:0]         res_t;

endpackage

`default_nettype wire

/* sv/imu_frame_decode_scale_remap.sv */
`default_nettype none

// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: data_byte, frame_stamp; tlast: frame_last
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: six axes, stamp_out; tuser: valid_res
// cfg       in   cfg_we (no wait)             cfg_index, cfg_data
//
// one byte beat per cycle unless the output stalls; results pass through stages a and b
// stage a: byte store, frame check, axis select and sign on the raw words
// stage b: one 17x25 multiply per axis into the output register
// reset clears the byte count, pipeline valids and config registers; no clearing pass
// a stalled output backs up through stage a into s_axis_tready

module imu_frame_decode_scale_remap
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [7:0] data_byte, [71:8] frame_stamp
    input  wire logic [imufd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic                           s_axis_tlast,

    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [39:0] accel_x, [79:40] accel_y, [119:80] accel_z,
    // [159:120] rate_x, [199:160] rate_y, [239:200] rate_z, [303:240] stamp_out
    output logic [imufd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // [0] valid_res
    output logic                                m_axis_tuser,

    input  wire logic                           cfg_we,
    input  wire logic [2:0]                     cfg_index,
    input  wire logic [imufd_pkg::SCALE_W-1:0]  cfg_data
);

    import imufd_pkg::*;

    // configuration registers
    logic [SCALE_W-1:0] accel_scale_reg;
    logic [SCALE_W-1:0] gyro_scale_reg;
    logic [1:0]         src_reg  [AXES];
    logic [1:0]         sign_reg [AXES];

    // byte collection
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [BYTE_W-1:0]  store_reg [FRAME_BYTES-1];

    // stage a
    logic               a_valid_reg;
    logic               a_valid_next;
    logic               a_ok_reg;
    sel_word_t          a_sel_reg  [2*AXES];
    sel_word_t          a_sel_next [2*AXES];
    logic [STAMP_W-1:0] a_stamp_reg;

    // output stage
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_ok_reg;
    res_t               out_res_reg  [2*AXES];
    res_t               out_res_next [2*AXES];
    logic [STAMP_W-1:0] out_stamp_reg;

    logic               in_fire;
    logic               a_ready;
    logic               b_ready;
    logic               frame_fire;
    logic               frame_ok;
    logic [BYTE_W-1:0]  frame_byte [FRAME_BYTES];
    word_t              word_w     [FRAME_WORDS];
    logic signed [PROD_W-1:0] prod_w [2*AXES];

    // handshake: the pipeline moves whenever the next stage is empty or draining
    assign b_ready       = !out_valid_reg || m_axis_tready;
    assign a_ready       = !a_valid_reg || b_ready;
    assign s_axis_tready = a_ready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign frame_fire    = in_fire && s_axis_tlast;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_scale_reg <= ACCEL_SCALE_RST;
            gyro_scale_reg  <= GYRO_SCALE_RST;
            src_reg[0]      <= SRC_COMP_X;
            src_reg[1]      <= SRC_COMP_Y;
            src_reg[2]      <= SRC_COMP_Z;
            sign_reg[0]     <= SIGN_POS;
            sign_reg[1]     <= SIGN_POS;
            sign_reg[2]     <= SIGN_POS;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ACCEL_SCALE: accel_scale_reg <= cfg_data;
                CFG_GYRO_SCALE:  gyro_scale_reg  <= cfg_data;
                CFG_SRC_X:       src_reg[0]      <= cfg_data[1:0];
                CFG_SRC_Y:       src_reg[1]      <= cfg_data[1:0];
                CFG_SRC_Z:       src_reg[2]      <= cfg_data[1:0];
                CFG_SIGN_X:      sign_reg[0]     <= cfg_data[1:0];
                CFG_SIGN_Y:      sign_reg[1]     <= cfg_data[1:0];
                CFG_SIGN_Z:      sign_reg[2]     <= cfg_data[1:0];
                default:         ;
            endcase
        end
    end

    // byte count: saturates on long frames, back to zero after the last beat
    always_comb
    begin
        if (s_axis_tlast)
            count_next = '0;
        else if (count_reg == COUNT_MAX)
            count_next = COUNT_MAX;
        else
            count_next = count_reg + COUNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (in_fire)
            count_reg <= count_next;
    end

    // the last byte of a good frame is taken straight from the bus, so only
    // the first eleven need storage; later bytes are dropped
    always_ff @(posedge clk)
    begin
        if (in_fire && count_reg < COUNT_W'(FRAME_BYTES - 1))
            store_reg[count_reg] <= s_axis_tdata[BYTE_W-1:0];
    end

    // frame assembly and check
    always_comb
    begin
        for (int i = 0; i < FRAME_BYTES - 1; i++)
            frame_byte[i] = store_reg[i];
        frame_byte[FRAME_BYTES-1] = s_axis_tdata[BYTE_W-1:0];
        for (int w = 0; w < FRAME_WORDS; w++)
            word_w[w] = {frame_byte[2*w+1], frame_byte[2*w]};
    end

    assign frame_ok = (count_reg == COUNT_W'(FRAME_BYTES - 1))
                   && (accel_scale_reg != '0) && (gyro_scale_reg != '0);

    // axis remap: pick the source word and apply the sign before scaling,
    // -(w*s) and (-w)*s agree, so the multiply sees one 17-bit operand
    always_comb
    begin
        word_t     pick;
        sel_word_t pick_ext;
        for (int g = 0; g < 2; g++)
        begin
            for (int k = 0; k < AXES; k++)
            begin
                pick = '0;
                case (src_reg[k])
                    SRC_COMP_X: pick = word_w[AXES*g];
                    SRC_COMP_Y: pick = word_w[AXES*g + 1];
                    SRC_COMP_Z: pick = word_w[AXES*g + 2];
                    default:    pick = '0;
                endcase
                pick_ext = {pick[WORD_W-1], pick};
                if (!frame_ok || src_reg[k] == SRC_NONE)
                    a_sel_next[AXES*g + k] = '0;
                else if (sign_reg[k] == SIGN_POS)
                    a_sel_next[AXES*g + k] = pick_ext;
                else if (sign_reg[k] == SIGN_NEG)
                    a_sel_next[AXES*g + k] = -pick_ext;
                else
                    a_sel_next[AXES*g + k] = '0;
            end
        end
    end

    assign a_valid_next = a_ready ? frame_fire : a_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= a_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && frame_fire)
        begin
            a_ok_reg    <= frame_ok;
            a_stamp_reg <= s_axis_tdata[IN_DATA_W-1:BYTE_W];
            for (int i = 0; i < 2*AXES; i++)
                a_sel_reg[i] <= a_sel_next[i];
        end
    end

    // scaling: signed word times unsigned Q8.16 scale, exact, kept to 40 bits
    always_comb
    begin
        for (int i = 0; i < 2*AXES; i++)
        begin
            if (i < AXES)
                prod_w[i] = a_sel_reg[i] * $signed({1'b0, accel_scale_reg});
            else
                prod_w[i] = a_sel_reg[i] * $signed({1'b0, gyro_scale_reg});
            out_res_next[i] = prod_w[i][RES_W-1:0];
        end
    end

    assign out_valid_next = b_ready ? a_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            out_ok_reg    <= a_ok_reg;
            out_stamp_reg <= a_stamp_reg;
            for (int i = 0; i < 2*AXES; i++)
                out_res_reg[i] <= out_res_next[i];
        end
    end

    // output beat
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_ok_reg;
    assign m_axis_tdata  = {out_stamp_reg,
                            out_res_reg[5], out_res_reg[4], out_res_reg[3],
                            out_res_reg[2], out_res_reg[1], out_res_reg[0]};

    // a rejected frame carries zero data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[6*RES_W-1:0] == '0)
        else $error("rejected frame with nonzero axis data");

    // the count restarts after every last byte
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && s_axis_tlast |=> count_reg == '0)
        else $error("byte count not cleared after last beat");

    // an overlong frame keeps the count pinned
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !s_axis_tlast && count_reg == COUNT_MAX |=> count_reg == COUNT_MAX)
        else $error("byte count left saturation");

    // a stage a result moving on always lands in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && b_ready |=> out_valid_reg)
        else $error("frame lost between stage a and output");

endmodule

`default_nettype wire

/* test/tb_imu_frame_decode_scale_remap.sv */
module tb_imu_frame_decode_scale_remap;

    timeunit 1ns;
    timeprecision 1ps;

    import imufd_pkg::*;

    // run shape
    localparam int RAND_PHASES     = 8;
    localparam int PHASE_BEATS     = 230;
    localparam int DIR_ROWS        = 3;
    localparam int MAX_GAP         = 17;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_AFTER      = 60;
    localparam int HOLD_CYCLES     = 600;
    localparam int WATCHDOG_LIMIT  = 3000;

    // sign patterns that are neither plus nor minus one
    localparam logic [1:0] SIGN_ZERO = 2'b00;
    localparam logic [1:0] SIGN_ODD  = 2'b10;

    // one frame result, laid out as {tuser, tdata}
    typedef struct packed {
        logic             valid;
        logic [63:0]      stamp;
        res_t [2:0]       rate;
        res_t [2:0]       accel;
    } motion_t;

    // directed frame: byte count, bytes from the lowest up, typed result
    typedef struct packed {
        logic [4:0]       nbytes;
        logic [127:0]     payload;
        motion_t          want;
    } dir_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    // [7:0] data_byte, [71:8] frame_stamp
    logic [IN_DATA_W-1:0]       s_axis_tdata;
    logic                       s_axis_tlast;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    // [39:0] accel_x .. [239:200] rate_z, [303:240] stamp_out
    logic [OUT_DATA_W-1:0]      m_axis_tdata;
    // [0] valid_res
    logic                       m_axis_tuser;
    logic                       cfg_we;
    logic [2:0]                 cfg_index;
    logic [SCALE_W-1:0]         cfg_data;

    // predictor state, a private copy of the block's
    logic [COUNT_W-1:0]         seen_count;
    logic [7:0]                 seen_bytes [FRAME_BYTES];
    logic [SCALE_W-1:0]         accel_lsb;
    logic [SCALE_W-1:0]         gyro_lsb;
    logic [1:0]                 axis_src [AXES];
    logic [1:0]                 axis_sign [AXES];

    // results still owed by the block, oldest first
    motion_t                    frames_due [$];

    // typed result that replaces the prediction for the next frame
    motion_t                    typed_want;
    bit                         typed_armed;

    dir_row_t                   dir_rows [DIR_ROWS];
    bit                         tx_burst;
    bit                         rx_burst;
    bit                         hold_done;
    int unsigned                results_seen;
    int unsigned                mismatches;
    int unsigned                idle_cycles;

    imu_frame_decode_scale_remap dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // pick one scaled component and apply the axis sign; bad index or sign gives zero
    function automatic res_t orient(input longint v0, input longint v1, input longint v2,
                                    input logic [1:0] src, input logic [1:0] sgn);
        longint v;
        res_t   r;
        v = (src == SRC_COMP_X) ? v0 : (src == SRC_COMP_Y) ? v1 : v2;
        r = '0;
        if (src != SRC_NONE)
        begin
            if (sgn == SIGN_POS)
                r = v[RES_W-1:0];
            else if (sgn == SIGN_NEG)
            begin
                v = -v;
                r = v[RES_W-1:0];
            end
        end
        return r;
    endfunction

    // mirror a register write into the predictor
    task automatic store_setting(input logic [2:0] idx, input logic [SCALE_W-1:0] val);
        case (cfg_idx_t'(idx))
            CFG_ACCEL_SCALE: accel_lsb    = val;
            CFG_GYRO_SCALE:  gyro_lsb     = val;
            CFG_SRC_X:       axis_src[0]  = val[1:0];
            CFG_SRC_Y:       axis_src[1]  = val[1:0];
            CFG_SRC_Z:       axis_src[2]  = val[1:0];
            CFG_SIGN_X:      axis_sign[0] = val[1:0];
            CFG_SIGN_Y:      axis_sign[1] = val[1:0];
            CFG_SIGN_Z:      axis_sign[2] = val[1:0];
            default: ;
        endcase
    endtask

    // take one byte beat; on the last byte of a frame produce the decoded result
    task automatic track_byte(input logic [7:0] b, input logic last, input logic [63:0] stamp,
                              output logic emit, output motion_t m);
        logic [4:0] total;
        longint     acc [AXES];
        longint     gyr [AXES];
        int         k;
        if (seen_count < FRAME_BYTES)
            seen_bytes[seen_count] = b;
        total = 5'(seen_count) + 5'd1;
        if (total > 5'(COUNT_MAX))
            total = 5'(COUNT_MAX);
        emit = last;
        m = '0;
        if (!last)
            seen_count = total[COUNT_W-1:0];
        else
        begin
            seen_count = '0;
            m.stamp = stamp;
            if (total == FRAME_BYTES && accel_lsb != '0 && gyro_lsb != '0)
            begin
                // little-endian signed words times the unsigned q8.16 scales
                for (k = 0; k < AXES; k++)
                begin
                    acc[k] = longint'($signed({seen_bytes[2*k+1], seen_bytes[2*k]}))
                             * longint'(accel_lsb);
                    gyr[k] = longint'($signed({seen_bytes[2*k+7], seen_bytes[2*k+6]}))
                             * longint'(gyro_lsb);
                end
                for (k = 0; k < AXES; k++)
                begin
                    m.accel[k] = orient(acc[0], acc[1], acc[2], axis_src[k], axis_sign[k]);
                    m.rate[k]  = orient(gyr[0], gyr[1], gyr[2], axis_src[k], axis_sign[k]);
                end
                m.valid = 1'b1;
            end
        end
    endtask

    // offer one byte beat after a drawn gap; returns at the falling edge after acceptance
    task automatic send_beat(input logic [7:0] b, input logic last, input logic [63:0] stamp);
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        if ($urandom_range(0, 40) == 0)
            tx_burst = !tx_burst;
        if (gap != 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {stamp, b};
        s_axis_tlast  = last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // wait for every owed result, then let the pipeline settle
    task automatic drain_pipeline;
        while (frames_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // monitor: config mirror, input beats into the predictor, output beats against it
    always @(posedge clk)
    begin : monitor
        logic    emit;
        logic    busy;
        motion_t m;
        motion_t got;
        motion_t want;
        int      k;
        if (rst_n)
        begin
            busy = 1'b0;
            if (cfg_we)
            begin
                store_setting(cfg_index, cfg_data);
                busy = 1'b1;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                track_byte(s_axis_tdata[7:0], s_axis_tlast, s_axis_tdata[71:8], emit, m);
                if (emit)
                begin
                    // directed rows carry their own typed result
                    if (typed_armed)
                    begin
                        m = typed_want;
                        typed_armed = 1'b0;
                    end
                    frames_due.push_back(m);
                end
                busy = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tuser, m_axis_tdata};
                results_seen++;
                busy = 1'b1;
                if (frames_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result beat with nothing expected, expected none got %h",
                             $time, got);
                end
                else
                begin
                    want = frames_due.pop_front();
                    for (k = 0; k < AXES; k++)
                    begin
                        if (got.accel[k] !== want.accel[k])
                        begin
                            mismatches++;
                            $display("%0t: accel[%0d] expected %h got %h",
                                     $time, k, want.accel[k], got.accel[k]);
                        end
                        if (got.rate[k] !== want.rate[k])
                        begin
                            mismatches++;
                            $display("%0t: rate[%0d] expected %h got %h",
                                     $time, k, want.rate[k], got.rate[k]);
                        end
                    end
                    if (got.stamp !== want.stamp)
                    begin
                        mismatches++;
                        $display("%0t: stamp expected %h got %h", $time, want.stamp, got.stamp);
                    end
                    if (got.valid !== want.valid)
                    begin
                        mismatches++;
                        $display("%0t: valid expected %b got %b", $time, want.valid, got.valid);
                    end
                end
            end
            idle_cycles = busy ? 0 : idle_cycles + 1;
        end
    end

    // receiver: random hold-offs, bursts with none, and one long stall to back up the input
    initial
    begin : receiver
        int unsigned w;
        m_axis_tready = 1'b0;
        while (rst_n !== 1'b1)
            @(negedge clk);
        forever
        begin
            // the long stall starts only while the sender is offering beats
            if (!hold_done && results_seen >= HOLD_AFTER && s_axis_tvalid)
            begin
                hold_done = 1'b1;
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            w = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            if ($urandom_range(0, 40) == 0)
                rx_burst = !rx_burst;
            if (w != 0)
            begin
                m_axis_tready = 1'b0;
                repeat (w) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            @(negedge clk);
        end
    end

    // nothing accepted for too long means the block hung
    initial
    begin : watchdog
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("tb_imu_frame_decode_scale_remap NOT OK");
        $finish;
    end

    initial
    begin : stimulus
        logic [SCALE_W-1:0] setting [8];
        logic [7:0]         b;
        int unsigned        r;
        int unsigned        k;
        int unsigned        fl;
        int unsigned        phase;
        int unsigned        sent;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        typed_armed   = 1'b0;
        tx_burst      = 1'b0;
        rx_burst      = 1'b0;
        hold_done     = 1'b0;
        results_seen  = 0;
        mismatches    = 0;
        idle_cycles   = 0;

        // predictor at its reset values
        seen_count   = '0;
        accel_lsb    = ACCEL_SCALE_RST;
        gyro_lsb     = GYRO_SCALE_RST;
        axis_src[0]  = SRC_COMP_X;
        axis_src[1]  = SRC_COMP_Y;
        axis_src[2]  = SRC_COMP_Z;
        axis_sign[0] = SIGN_POS;
        axis_sign[1] = SIGN_POS;
        axis_sign[2] = SIGN_POS;
        for (k = 0; k < FRAME_BYTES; k++)
            seen_bytes[k] = '0;

        // directed frames at reset settings
        //   single byte frame: wrong length, stamp all zeros
        dir_rows[0] = {5'd1, 128'hFF, 1'b0, 64'h0, 240'h0};
        //   full frame of extreme words 7fff 8000 ffff 0001 8000 7fff, stamp all ones
        dir_rows[1] = {5'd12, 128'h0000_0000_7FFF_8000_0001_FFFF_8000_7FFF,
                       1'b1, 64'hFFFF_FFFF_FFFF_FFFF,
                       40'h00_01FF_FC00, 40'hFF_FE00_0000, 40'h00_0000_0400,
                       40'hFF_FFFF_FFF0, 40'hFF_FFF8_0000, 40'h00_0007_FFF0};
        //   sixteen bytes: count saturates, result invalid
        dir_rows[2] = {5'd16, 128'h1234_5678_9ABC_DEF0_0FED_CBA9_8765_4321,
                       1'b0, 64'h8000_0000_0000_0001, 240'h0};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (r = 0; r < DIR_ROWS; r++)
        begin
            typed_want  = dir_rows[r].want;
            typed_armed = 1'b1;
            for (k = 0; k < dir_rows[r].nbytes; k++)
                send_beat(dir_rows[r].payload[8*k +: 8], k == dir_rows[r].nbytes - 1,
                          dir_rows[r].want.stamp);
        end
        s_axis_tvalid = 1'b0;

        for (phase = 0; phase < RAND_PHASES; phase++)
        begin
            drain_pipeline();

            // settings for this phase: extremes and special cases first, then random
            case (phase)
                0:
                begin
                    setting[CFG_ACCEL_SCALE] = '1;
                    setting[CFG_GYRO_SCALE]  = 24'd1;
                    setting[CFG_SRC_X]       = 24'(SRC_COMP_Z);
                    setting[CFG_SRC_Y]       = 24'(SRC_COMP_X);
                    setting[CFG_SRC_Z]       = 24'(SRC_COMP_Y);
                    setting[CFG_SIGN_X]      = 24'(SIGN_NEG);
                    setting[CFG_SIGN_Y]      = 24'(SIGN_POS);
                    setting[CFG_SIGN_Z]      = 24'(SIGN_NEG);
                end
                1:
                begin
                    // zero accel scale marks every frame invalid
                    setting[CFG_ACCEL_SCALE] = '0;
                    setting[CFG_GYRO_SCALE]  = '1;
                    setting[CFG_SRC_X]       = 24'(SRC_COMP_X);
                    setting[CFG_SRC_Y]       = 24'(SRC_COMP_Y);
                    setting[CFG_SRC_Z]       = 24'(SRC_COMP_Z);
                    setting[CFG_SIGN_X]      = 24'(SIGN_POS);
                    setting[CFG_SIGN_Y]      = 24'(SIGN_POS);
                    setting[CFG_SIGN_Z]      = 24'(SIGN_POS);
                end
                2:
                begin
                    // zero gyro scale
                    setting[CFG_ACCEL_SCALE] = 24'd1;
                    setting[CFG_GYRO_SCALE]  = '0;
                end
                3:
                begin
                    // unused source index, zero sign and the odd sign pattern
                    setting[CFG_ACCEL_SCALE] = 24'($urandom) | 24'd1;
                    setting[CFG_GYRO_SCALE]  = 24'($urandom) | 24'd1;
                    setting[CFG_SRC_X]       = 24'(SRC_NONE);
                    setting[CFG_SRC_Y]       = 24'(SRC_COMP_Z);
                    setting[CFG_SRC_Z]       = 24'(SRC_COMP_X);
                    setting[CFG_SIGN_X]      = 24'(SIGN_POS);
                    setting[CFG_SIGN_Y]      = 24'(SIGN_ZERO);
                    setting[CFG_SIGN_Z]      = 24'(SIGN_ODD);
                end
                default:
                begin
                    // fully random, with junk above the two-bit fields
                    for (k = 0; k < 2; k++)
                        setting[k] = ($urandom_range(0, 7) == 0) ? '0 : 24'($urandom);
                    for (k = 2; k < 8; k++)
                        setting[k] = {22'($urandom), 2'($urandom_range(0, 3))};
                end
            endcase

            for (k = 0; k < 8; k++)
            begin
                cfg_we    = 1'b1;
                cfg_index = 3'(k);
                cfg_data  = setting[k];
                @(negedge clk);
            end
            cfg_we = 1'b0;

            // mostly well-formed frames, the rest short or overlong
            sent = 0;
            while (sent < PHASE_BEATS)
            begin
                fl = ($urandom_range(0, 4) != 0) ? FRAME_BYTES : $urandom_range(1, 20);
                for (k = 0; k < fl; k++)
                begin
                    case ($urandom_range(0, 11))
                        0:       b = 8'h00;
                        1:       b = 8'hFF;
                        2:       b = 8'h80;
                        3:       b = 8'h7F;
                        default: b = 8'($urandom);
                    endcase
                    send_beat(b, k == fl - 1, {$urandom, $urandom});
                end
                sent += fl;
            end
            s_axis_tvalid = 1'b0;
        end

        drain_pipeline();
        if (mismatches == 0 && frames_due.size() == 0)
            $display("tb_imu_frame_decode_scale_remap OK");
        else
            $display("tb_imu_frame_decode_scale_remap NOT OK");
        $finish;
    end

endmodule
